// ===== hw/rtl/ppu_bus_nametable_mirror_unit_macros.svh =====
// assertion helpers used by the mirror unit rtl file
// both expect clk_i and rst_ni in the enclosing module
`ifndef PPU_BUS_NAMETABLE_MIRROR_UNIT_MACROS_SVH
`define PPU_BUS_NAMETABLE_MIRROR_UNIT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PNM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pnm check failed");

// consequent holds in the cycle after the antecedent
`define PNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pnm check failed");

`endif

// ===== hw/rtl/pnm_pkg.sv =====
package pnm_pkg;

  // request payload widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned MODE_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WRITABLE = 2'd1;

  // operation codes (code 3 behaves as a read)
  localparam logic [OP_W-1:0] OP_READ    = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd1;
  localparam logic [OP_W-1:0] OP_PRELOAD = 2'd2;

  // mirroring modes, codes above four-screen act as four-screen
  localparam logic [MODE_W-1:0] MIRROR_SINGLE_LOWER = 3'd0;
  localparam logic [MODE_W-1:0] MIRROR_SINGLE_UPPER = 3'd1;
  localparam logic [MODE_W-1:0] MIRROR_VERT         = 3'd2;
  localparam logic [MODE_W-1:0] MIRROR_HORIZ        = 3'd3;
  localparam logic [MODE_W-1:0] MIRROR_FOUR_SCREEN  = 3'd4;

  // storage
  localparam int unsigned PATTERN_BYTES   = 8192;
  localparam int unsigned NAMETABLE_BYTES = 1024;
  localparam int unsigned NT_DEPTH        = 4 * NAMETABLE_BYTES; // internal plus extra
  localparam int unsigned PAL_DEPTH       = 32;

  localparam int unsigned PAT_AW = $clog2(PATTERN_BYTES);
  localparam int unsigned NT_AW  = $clog2(NT_DEPTH);
  localparam int unsigned PAL_AW = $clog2(PAL_DEPTH);

  // which store answers an access
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_PAT,
    SEL_NT,
    SEL_PAL
  } sel_e;

endpackage

// ===== hw/rtl/pnm_ram.sv =====
module pnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data only moves on a read, so it holds while a result waits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ppu_bus_nametable_mirror_unit.sv =====
// channel   | dir | handshake                  | payload
// ----------+-----+----------------------------+-------------------------------------
// request   | in  | in_valid_i / in_stall_o    | operation_i, address_i, write_data_i
// result    | out | out_valid_o / out_stall_i  | read_data_o
// config    | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one request per cycle unless stalled, set by the single port of each ram (at most
// one access per request); a request goes via the read stage to the output register
// after reset a clearing pass zeroes the nametable and palette rams, requests are
// held off meanwhile (config writes are taken at any time); a stalled result holds
// the read stage; requests stall only while clearing or while the read stage is held

`include "ppu_bus_nametable_mirror_unit_macros.svh"

module ppu_bus_nametable_mirror_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pnm_pkg::OP_W-1:0]         operation_i,
  input  logic [pnm_pkg::ADDR_W-1:0]       address_i,
  input  logic [pnm_pkg::DATA_W-1:0]       write_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pnm_pkg::DATA_W-1:0]       read_data_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pnm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pnm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import pnm_pkg::*;

  // configuration registers
  logic [MODE_W-1:0] mirror_mode_q;
  logic              pattern_writable_q;

  // clearing pass
  logic             clr_q;
  logic [NT_AW-1:0] clr_cnt_q;

  // read stage (ram access in flight) and output register
  logic             p1_q;
  sel_e             p1_sel_q;
  logic             out_valid_q;
  logic [DATA_W-1:0] read_data_q;

  logic in_accept;
  logic p1_adv;

  // address decode
  logic             is_rd;
  logic             is_wr;
  logic             mapped;
  logic             in_pat;
  logic             in_pal;
  sel_e             sel;
  logic             wr_ok;
  logic [11:0]      rel;
  logic [NT_AW-1:0] nt_idx;
  logic [PAL_AW-1:0] pal_idx;
  logic [DATA_W-1:0] result_mux;

  // ram ports
  logic              pat_en;
  logic [DATA_W-1:0] pat_rdata;
  logic              nt_en;
  logic              nt_we;
  logic [NT_AW-1:0]  nt_addr;
  logic [DATA_W-1:0] nt_wdata;
  logic [DATA_W-1:0] nt_rdata;
  logic              pal_clr;
  logic              pal_en;
  logic              pal_we;
  logic [PAL_AW-1:0] pal_addr;
  logic [DATA_W-1:0] pal_wdata;
  logic [DATA_W-1:0] pal_rdata;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------

  // read stage moves on when the output register is free or being emptied
  assign p1_adv      = p1_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = clr_q || (p1_q && !p1_adv);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // --------------------------------------------------------------------------
  // decode
  // --------------------------------------------------------------------------

  assign is_wr  = (operation_i == OP_WRITE) || (operation_i == OP_PRELOAD);
  assign is_rd  = !is_wr;
  assign mapped = (address_i[15:14] == 2'b00);
  assign in_pat = (address_i[13] == 1'b0);
  assign in_pal = (address_i[13:8] == 6'h3F);

  // offset into the 4 KiB nametable window, repeats every 4 KiB
  assign rel = address_i[11:0];

  always_comb begin
    case (mirror_mode_q)
      MIRROR_SINGLE_LOWER: nt_idx = {1'b0, 1'b0, rel[9:0]};
      MIRROR_SINGLE_UPPER: nt_idx = {1'b0, 1'b1, rel[9:0]};
      MIRROR_VERT:         nt_idx = {1'b0, rel[10], rel[9:0]};
      MIRROR_HORIZ:        nt_idx = {1'b0, rel[11], rel[9:0]};
      // four-screen: upper half of the window lands in the extra ram
      default:             nt_idx = rel;
    endcase
  end

  // background colour entries of the sprite palettes alias the tile palettes
  always_comb begin
    pal_idx = address_i[PAL_AW-1:0];
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_comb begin
    if (!mapped) begin
      sel = SEL_NONE;
    end else if (in_pat) begin
      sel = SEL_PAT;
    end else if (in_pal) begin
      sel = SEL_PAL;
    end else begin
      sel = SEL_NT;
    end
  end

  // protected pattern space drops plain writes, preloads go through
  assign wr_ok = is_wr && mapped &&
                 !(in_pat && (operation_i == OP_WRITE) && !pattern_writable_q);

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------

  assign pat_en = in_accept && (sel == SEL_PAT) && (is_rd || wr_ok);

  pnm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PATTERN_BYTES)
  ) u_pat_ram (
    .clk_i   (clk_i),
    .en_i    (pat_en),
    .we_i    (wr_ok),
    .addr_i  (address_i[PAT_AW-1:0]),
    .wdata_i (write_data_i),
    .rdata_o (pat_rdata)
  );

  // internal nametable ram in the lower half, four-screen extra ram above
  assign nt_en    = clr_q || (in_accept && (sel == SEL_NT) && (is_rd || wr_ok));
  assign nt_we    = clr_q || wr_ok;
  assign nt_addr  = clr_q ? clr_cnt_q : nt_idx;
  assign nt_wdata = clr_q ? '0 : write_data_i;

  pnm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NT_DEPTH)
  ) u_nt_ram (
    .clk_i   (clk_i),
    .en_i    (nt_en),
    .we_i    (nt_we),
    .addr_i  (nt_addr),
    .wdata_i (nt_wdata),
    .rdata_o (nt_rdata)
  );

  // palette is zeroed during the first cycles of the clearing pass
  assign pal_clr   = clr_q && (clr_cnt_q[NT_AW-1:PAL_AW] == '0);
  assign pal_en    = pal_clr || (in_accept && (sel == SEL_PAL) && (is_rd || wr_ok));
  assign pal_we    = pal_clr || wr_ok;
  assign pal_addr  = pal_clr ? clr_cnt_q[PAL_AW-1:0] : pal_idx;
  assign pal_wdata = pal_clr ? '0 : write_data_i;

  pnm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (PAL_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .en_i    (pal_en),
    .we_i    (pal_we),
    .addr_i  (pal_addr),
    .wdata_i (pal_wdata),
    .rdata_o (pal_rdata)
  );

  // --------------------------------------------------------------------------
  // control registers
  // --------------------------------------------------------------------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_mode_q      <= MIRROR_HORIZ;
      pattern_writable_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIRROR_MODE:      mirror_mode_q      <= cfg_data_i[MODE_W-1:0];
        CFG_PATTERN_WRITABLE: pattern_writable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + NT_AW'(1);
      if (clr_cnt_q == NT_AW'(NT_DEPTH - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // read stage: remembers which store answers the request in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q     <= 1'b0;
      p1_sel_q <= SEL_NONE;
    end else if (in_accept) begin
      p1_q     <= 1'b1;
      // writes and preloads give zero, like unmapped reads
      p1_sel_q <= is_rd ? sel : SEL_NONE;
    end else if (p1_adv) begin
      p1_q <= 1'b0;
    end
  end

  always_comb begin
    unique case (p1_sel_q)
      SEL_PAT: result_mux = pat_rdata;
      SEL_NT:  result_mux = nt_rdata;
      SEL_PAL: result_mux = pal_rdata;
      default: result_mux = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      read_data_q <= result_mux;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------

  `PNM_ASSERT_NOW(a_no_req_while_clearing, clr_q, in_stall_o && !in_accept)
  `PNM_ASSERT_NEXT(a_clear_ends, clr_q && (clr_cnt_q == NT_AW'(NT_DEPTH - 1)), !clr_q)
  `PNM_ASSERT_NEXT(a_accept_fills_stage, in_accept, p1_q)
  `PNM_ASSERT_NEXT(a_held_stage_kept, p1_q && !p1_adv, p1_q && $stable(p1_sel_q))
  `PNM_ASSERT_NEXT(a_non_read_zero, p1_adv && (p1_sel_q == SEL_NONE),
                   out_valid_o && (read_data_o == '0))

endmodule
